### hw/rtl/udiv_pkg.sv
package udiv_pkg;

  localparam int WORD_W = 64;
  localparam int WIDE_W = 2 * WORD_W;
  // one quotient bit per step
  localparam int STEPS  = WIDE_W;
  localparam int CNT_W  = $clog2(STEPS);

  typedef struct packed {
    logic [WORD_W-1:0] dividend_high;
    logic [WORD_W-1:0] dividend_low;
    logic [WORD_W-1:0] divisor_high;
    logic [WORD_W-1:0] divisor_low;
  } udiv_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] quotient_high;
    logic [WORD_W-1:0] quotient_low;
    logic [WORD_W-1:0] remainder_high;
    logic [WORD_W-1:0] remainder_low;
    logic              divide_by_zero;
  } udiv_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture operands
    logic step;   // one shift-subtract step
    logic write;  // move result into the output register
  } udiv_cmd_t;

endpackage

### hw/rtl/unsigned_128_bit_divider_top.sv
// 128-bit unsigned divider, restoring shift-subtract.
//
// Input channel (in_valid/in_ready/in_data): one beat carries the dividend
// and divisor, each as 64-bit high and low halves. Output channel
// (out_valid/out_ready/out_data): one beat per input beat with quotient,
// remainder and a divide_by_zero flag.
//
// Sequence: operands load at the accepting edge, then 128 steps of the
// 129-bit subtractor, then one write moves the result to the output register.
// in_ready is high only while idle, so a new beat waits for that write.
// A zero divisor still runs the full sequence and returns divide_by_zero=1
// with all quotient and remainder fields zero.
//
// The result sits in its own output register, so it may wait for out_ready
// while the next division is already running. If the receiver still holds
// the previous result when a new one is done, the block waits in its write
// state and holds off further input until the output register frees up.
//
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out_valid; any division in flight is discarded.
module unsigned_128_bit_divider_top
  import udiv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  udiv_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output udiv_out_t out_data
);

  udiv_cmd_t cmd;

  // sequencing: step count and handshakes
  udiv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // operand, partial remainder and result registers
  udiv_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after accept");

  // a new result appears only out of the busy phase
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised without a division in flight");

  // divide by zero gives all-zero fields
  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.divide_by_zero) |->
      (out_data.quotient_high == '0 && out_data.quotient_low == '0 &&
       out_data.remainder_high == '0 && out_data.remainder_low == '0))
    else $error("nonzero fields on divide by zero");
`endif

endmodule

### hw/rtl/udiv_ctrl.sv
module udiv_ctrl
  import udiv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output udiv_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WRITE
  } state_t;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;

  always_comb begin
    cmd.load  = (state_r == ST_IDLE) && in_valid;
    cmd.step  = (state_r == ST_RUN);
    cmd.write = (state_r == ST_WRITE) && (!out_valid_r || out_ready);
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a write refills the output register, otherwise a taken beat empties it
      if (cmd.write) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cnt_r   <= '0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_STEP) begin
            state_r <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          // wait here until the output register is free
          if (cmd.write) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/udiv_dp.sv
module udiv_dp
  import udiv_pkg::*;
(
  input  logic      clk,
  input  udiv_cmd_t cmd,
  input  udiv_in_t  in_data,
  output udiv_out_t out_data
);

  logic [WIDE_W-1:0] rem_r, rem_nxt;
  logic [WIDE_W-1:0] quo_r, quo_nxt;  // dividend bits shift out, quotient bits shift in
  logic [WIDE_W-1:0] den_r;
  logic              dbz_r;
  udiv_out_t         res_r, res_nxt;

  logic [WIDE_W:0]   part;
  logic [WIDE_W:0]   diff;
  logic              fits;

  always_comb begin
    part    = {rem_r, quo_r[WIDE_W-1]};
    diff    = part - {1'b0, den_r};
    fits    = !diff[WIDE_W];
    // partial remainder stays below the divisor, so it fits in WIDE_W bits
    rem_nxt = fits ? diff[WIDE_W-1:0] : part[WIDE_W-1:0];
    quo_nxt = {quo_r[WIDE_W-2:0], fits};
  end

  always_comb begin
    if (dbz_r) begin
      res_nxt                = '0;
      res_nxt.divide_by_zero = 1'b1;
    end else begin
      res_nxt.quotient_high  = quo_r[WIDE_W-1:WORD_W];
      res_nxt.quotient_low   = quo_r[WORD_W-1:0];
      res_nxt.remainder_high = rem_r[WIDE_W-1:WORD_W];
      res_nxt.remainder_low  = rem_r[WORD_W-1:0];
      res_nxt.divide_by_zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= '0;
      quo_r <= {in_data.dividend_high, in_data.dividend_low};
      den_r <= {in_data.divisor_high, in_data.divisor_low};
      dbz_r <= ({in_data.divisor_high, in_data.divisor_low} == '0);
    end else if (cmd.step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.write) begin
      res_r <= res_nxt;
    end
  end

  assign out_data = res_r;

endmodule

### verif/unsigned_128_bit_divider_top_tb.sv
// Self-checking bench for the 128-bit restoring divider.
//
// A short table of hand-picked divisions runs first: zero divisor, divisor of
// one, equal operands, dividend below divisor, equal bit lengths, all-ones
// extremes. After that come about 400 random divisions shaped toward those
// same corners, spread over phases with different idling on either side.
// Beats without a hand-written answer are predicted by a shift-subtract model
// in this file. Results are checked in order against the queue of predictions.
module unsigned_128_bit_divider_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import udiv_pkg::*;

  // A settle window of DRAIN_CYCLES is used at the end. The cycle limit is
  // several times the slowest legal run.
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam logic [WORD_W-1:0] Z       = 64'd0;
  localparam logic [WORD_W-1:0] ONE     = 64'd1;
  localparam logic [WORD_W-1:0] ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [WORD_W-1:0] ONES_M1 = 64'hFFFF_FFFF_FFFF_FFFE;
  localparam logic [WORD_W-1:0] MSB     = 64'h8000_0000_0000_0000;
  localparam logic [WORD_W-1:0] ALT_A   = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [WORD_W-1:0] ALT_5   = 64'h5555_5555_5555_5555;
  localparam logic [WORD_W-1:0] MIX_H   = 64'h0123_4567_89AB_CDEF;
  localparam logic [WORD_W-1:0] MIX_L   = 64'hFEDC_BA98_7654_3210;

  // One directed row: operands, plus a hand-written answer where it is obvious.
  typedef struct packed {
    udiv_in_t  op;
    logic      has_answer;
    udiv_out_t answer;
  } div_case_t;

  localparam int N_DIRECTED = 23;
  localparam div_case_t DIRECTED [N_DIRECTED] = '{
    // zero divisor: flag set, everything else zero
    '{'{Z, Z, Z, Z},                 1'b1, '{Z, Z, Z, Z, 1'b1}},
    '{'{ONES, ONES, Z, Z},           1'b1, '{Z, Z, Z, Z, 1'b1}},
    // divisor of one: quotient is the dividend
    '{'{Z, Z, Z, ONE},               1'b1, '{Z, Z, Z, Z, 1'b0}},
    '{'{ONES, ONES, Z, ONE},         1'b1, '{ONES, ONES, Z, Z, 1'b0}},
    '{'{MSB, Z, Z, ONE},             1'b1, '{MSB, Z, Z, Z, 1'b0}},
    // equal operands
    '{'{ONES, ONES, ONES, ONES},     1'b1, '{Z, ONE, Z, Z, 1'b0}},
    '{'{Z, 64'd7, Z, 64'd7},         1'b1, '{Z, ONE, Z, Z, 1'b0}},
    // dividend below divisor: remainder is the dividend
    '{'{Z, ONE, ONES, ONES},         1'b1, '{Z, Z, Z, ONE, 1'b0}},
    '{'{ONES, ONES_M1, ONES, ONES},  1'b1, '{Z, Z, ONES, ONES_M1, 1'b0}},
    '{'{Z, 64'd5, Z, 64'd7},         1'b1, '{Z, Z, Z, 64'd5, 1'b0}},
    '{'{Z, ONES, MSB, Z},            1'b1, '{Z, Z, Z, ONES, 1'b0}},
    '{'{Z, Z, ONES, ONES},           1'b1, '{Z, Z, Z, Z, 1'b0}},
    // equal bit lengths: single step, quotient 0 or 1
    '{'{Z, 64'd13, Z, 64'd9},        1'b1, '{Z, ONE, Z, 64'd4, 1'b0}},
    '{'{Z, 64'd9, Z, 64'd13},        1'b1, '{Z, Z, Z, 64'd9, 1'b0}},
    '{'{ONES, ONES, ONES, ONES_M1},  1'b1, '{Z, ONE, Z, ONE, 1'b0}},
    // powers of two across the word boundary
    '{'{MSB, Z, Z, MSB},             1'b1, '{ONE, Z, Z, Z, 1'b0}},
    '{'{ONES, ONES, ONE, Z},         1'b1, '{Z, ONES, Z, ONES, 1'b0}},
    // full-length alignment and mixed patterns, left to the predictor
    '{'{Z, 64'd100, Z, 64'd7},       1'b0, '0},
    '{'{ONES, Z, Z, ONES},           1'b0, '0},
    '{'{ALT_A, ALT_A, Z, ALT_5},     1'b0, '0},
    '{'{ALT_5, ALT_5, ALT_A, ALT_A}, 1'b0, '0},
    '{'{ONES, ONES, Z, 64'd2},       1'b0, '0},
    '{'{MIX_H, MIX_L, Z, 64'd3},     1'b0, '0}
  };

  // Random phases: sender idle percent, receiver stall percent, beat count.
  // The pressure phase also parks the receiver for HOLD_CYCLES.
  localparam int N_PHASES       = 5;
  localparam int PRESSURE_PHASE = 4;
  localparam int unsigned PHASE_IDLE  [N_PHASES] = '{0, 81, 0, 9, 0};
  localparam int unsigned PHASE_STALL [N_PHASES] = '{0, 0, 81, 9, 0};
  localparam int unsigned PHASE_BEATS [N_PHASES] = '{90, 80, 80, 90, 60};

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  udiv_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  udiv_out_t out_data;

  // Predictions are appended at input acceptance; the checker walks them by
  // index so that each side owns exactly one variable.
  udiv_out_t   predicted_results [$];
  int unsigned results_checked = 0;
  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned holds_served   = 0;

  unsigned_128_bit_divider_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: align divisor MSB with dividend MSB, then one restoring
  // shift-subtract step per aligned position, quotient built MSB first.
  // ---------------------------------------------------------------------------
  function automatic int bit_length(logic [WIDE_W-1:0] v);
    for (int b = WIDE_W - 1; b >= 0; b--) begin
      if (v[b]) return b + 1;
    end
    return 0;
  endfunction

  function automatic udiv_out_t long_divide(udiv_in_t op);
    logic [WIDE_W-1:0] num;
    logic [WIDE_W-1:0] den;
    logic [WIDE_W-1:0] quo;
    logic [WIDE_W-1:0] rem;
    int                shift;
    udiv_out_t         res;
    num = {op.dividend_high, op.dividend_low};
    den = {op.divisor_high, op.divisor_low};
    res = '0;
    if (den == '0) begin
      // zero divisor: flag only, numeric fields stay zero
      res.divide_by_zero = 1'b1;
      return res;
    end
    shift = bit_length(num) - bit_length(den);
    if (shift < 0) shift = 0;
    den = den << shift;
    rem = num;
    quo = '0;
    for (int i = shift; i >= 0; i--) begin
      quo = quo << 1;
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
      den = den >> 1;
    end
    {res.quotient_high, res.quotient_low}   = quo;
    {res.remainder_high, res.remainder_low} = rem;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Random operands
  // ---------------------------------------------------------------------------
  // Random value of exactly len bits (len 0 gives zero).
  function automatic logic [WIDE_W-1:0] random_wide(int unsigned len);
    logic [WIDE_W-1:0] v;
    v = {$urandom, $urandom, $urandom, $urandom};
    if (len == 0) return '0;
    v = v >> (WIDE_W - len);
    v[len-1] = 1'b1;
    return v;
  endfunction

  // Mostly general divisions, with a steady share of the corner cases:
  // zero divisor, divisor one, near-equal operands, equal lengths, small
  // dividend.
  function automatic udiv_in_t random_division();
    logic [WIDE_W-1:0] a;
    logic [WIDE_W-1:0] b;
    int unsigned       pick;
    int unsigned       len;
    udiv_in_t          op;
    pick = $urandom_range(99);
    len  = ($urandom_range(3) == 0) ? WIDE_W : $urandom_range(WIDE_W, 1);
    a    = random_wide(len);
    if (pick < 6) begin
      b = '0;
    end else if (pick < 12) begin
      b = 128'd1;
    end else if (pick < 20) begin
      // a-1, a or a+1 (may wrap to zero at the extremes)
      b = a + 128'($urandom_range(2)) - 128'd1;
    end else if (pick < 32) begin
      b = random_wide(len);
    end else if (pick < 42) begin
      b = a;
      a = random_wide($urandom_range(len - 1, 0));
    end else begin
      b = random_wide($urandom_range(len, 1));
    end
    op.dividend_high = a[WIDE_W-1:WORD_W];
    op.dividend_low  = a[WORD_W-1:0];
    op.divisor_high  = b[WIDE_W-1:WORD_W];
    op.divisor_low   = b[WORD_W-1:0];
    return op;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: random gap, then hold the beat until accepted. in_valid is only
  // lowered inside a gap, so back-to-back beats never toggle it in one step.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input udiv_in_t op, input udiv_out_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted_results.push_back(res);
  endtask

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when requested so the block
  // backs up into its input.
  // ---------------------------------------------------------------------------
  initial begin : ready_driver
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: in-order compare, field by field.
  always @(posedge clk) begin : result_check
    udiv_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_checked >= predicted_results.size()) begin
        flag_error($sformatf("unexpected beat %p", out_data));
      end else begin
        want = predicted_results[results_checked];
        if (out_data.quotient_high !== want.quotient_high)
          flag_error($sformatf("beat %0d quotient_high exp %h got %h", results_checked,
                               want.quotient_high, out_data.quotient_high));
        if (out_data.quotient_low !== want.quotient_low)
          flag_error($sformatf("beat %0d quotient_low exp %h got %h", results_checked,
                               want.quotient_low, out_data.quotient_low));
        if (out_data.remainder_high !== want.remainder_high)
          flag_error($sformatf("beat %0d remainder_high exp %h got %h", results_checked,
                               want.remainder_high, out_data.remainder_high));
        if (out_data.remainder_low !== want.remainder_low)
          flag_error($sformatf("beat %0d remainder_low exp %h got %h", results_checked,
                               want.remainder_low, out_data.remainder_low));
        if (out_data.divide_by_zero !== want.divide_by_zero)
          flag_error($sformatf("beat %0d divide_by_zero exp %b got %b", results_checked,
                               want.divide_by_zero, out_data.divide_by_zero));
        results_checked <= results_checked + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    udiv_in_t op;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling
    foreach (DIRECTED[i]) begin
      send_beat(DIRECTED[i].op,
                DIRECTED[i].has_answer ? DIRECTED[i].answer : long_divide(DIRECTED[i].op));
    end

    // random phases
    for (int ph = 0; ph < N_PHASES; ph++) begin
      send_idle_pct  = PHASE_IDLE[ph];
      recv_stall_pct = PHASE_STALL[ph];
      if (ph == PRESSURE_PHASE) hold_requests++;
      for (int unsigned n = 0; n < PHASE_BEATS[ph]; n++) begin
        op = random_division();
        send_beat(op, long_divide(op));
      end
    end
    in_valid <= 1'b0;

    // drain, then let any stray beat show up
    while (results_checked < predicted_results.size()) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && results_checked == predicted_results.size()) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
